### rtl/max_abs_feature_scaler_defines.svh
// assertion macros used by the checker file
`ifndef MAX_ABS_FEATURE_SCALER_DEFINES_SVH
`define MAX_ABS_FEATURE_SCALER_DEFINES_SVH

// property checked only while reset is low
`define MAFS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define MAFS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/mafs_pkg.sv
package mafs_pkg;

   // fixed field widths
   localparam int INDEX_BITS  = 10;
   localparam int FIU_BITS    = INDEX_BITS + 1;
   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 2;
   localparam int FRAC_BITS   = 16;

   // parameter defaults
   localparam int DEF_NUM_FEATURES = 1024;
   localparam int DEF_VALUE_BITS   = 32;

   // request commands
   typedef enum logic [CMD_BITS-1:0] {
      CMD_OBSERVE = 2'd0,
      CMD_SCALE   = 2'd1,
      CMD_CLEAR   = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   // response status codes
   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_SAT   = 2'd2
   } status_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic sweep;
      logic eval;
      logic div_step;
      logic round;
      logic load_rsp;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic    sweep_last;
      logic    div_last;
      logic    need_div;
      cmd_type item_cmd;
   } dp_status_type;

endpackage

### rtl/mafs_ctrl.sv
module mafs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output mafs_pkg::ctrl_cmd_type  cmd,
   input  mafs_pkg::dp_status_type stat
);

   typedef enum logic [6:0] {
      ST_INIT  = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_EVAL  = 7'b0000100,
      ST_CLEAR = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_ROUND = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            case (stat.item_cmd)
               mafs_pkg::CMD_CLEAR: state_in = ST_CLEAR;
               mafs_pkg::CMD_SCALE: state_in = stat.need_div ? ST_DIV : ST_DONE;
               default:             state_in = ST_DONE;
            endcase
         end
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // output valid flag
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

### rtl/mafs_datapath.sv
module mafs_datapath #(
   parameter int NUM_FEATURES = mafs_pkg::DEF_NUM_FEATURES,
   parameter int VALUE_BITS   = mafs_pkg::DEF_VALUE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mafs_pkg::ctrl_cmd_type               cmd,
   output mafs_pkg::dp_status_type              stat,
   input  logic [mafs_pkg::CMD_BITS-1:0]        req_command,
   input  logic [mafs_pkg::INDEX_BITS-1:0]      req_index,
   input  logic [VALUE_BITS-1:0]                req_value,
   output logic [VALUE_BITS-1:0]                rsp_value,
   output mafs_pkg::status_type                 rsp_status
);

   localparam int IDX_SPAN  = 2 ** mafs_pkg::INDEX_BITS;
   localparam int DEPTH     = (NUM_FEATURES < IDX_SPAN) ? NUM_FEATURES : IDX_SPAN;
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int QBITS     = VALUE_BITS + mafs_pkg::FRAC_BITS;
   localparam int STEP_BITS = $clog2(QBITS);
   localparam int FB        = mafs_pkg::FRAC_BITS;
   localparam int FIUB      = mafs_pkg::FIU_BITS;

   localparam logic [FIUB-1:0]      DEPTH_LIM = FIUB'(DEPTH);
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(DEPTH - 1);
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(QBITS - 1);
   localparam logic [QBITS:0]       LIM_POS   = {{(FB + 2){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
   localparam logic [QBITS:0]       LIM_NEG   = {{(FB + 1){1'b0}}, 1'b1,
                                                 {(VALUE_BITS - 1){1'b0}}};

   // maximum table
   logic [VALUE_BITS-1:0] mem [DEPTH];
   logic                  mem_we;
   logic [ADDR_BITS-1:0]  mem_waddr;
   logic [VALUE_BITS-1:0] mem_wdata;
   logic [VALUE_BITS-1:0] rd_ff;

   // captured request
   mafs_pkg::cmd_type                item_cmd_ff, item_cmd_in;
   logic [mafs_pkg::INDEX_BITS-1:0]  item_idx_ff, item_idx_in;
   logic [VALUE_BITS-1:0]            item_val_ff, item_val_in;

   // control state
   logic [ADDR_BITS-1:0] sweep_ff, sweep_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [FIUB-1:0]      fiu_ff, fiu_in;

   // divider
   logic [QBITS-1:0]      quo_ff, quo_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] den_ff, den_in;
   logic [VALUE_BITS-1:0] num_ff, num_in;

   // result
   logic [VALUE_BITS-1:0] res_ff, res_in;
   logic                  res_neg_ff, res_neg_in;
   mafs_pkg::status_type  res_stat_ff, res_stat_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   mafs_pkg::status_type  rsp_status_ff, rsp_status_in;

   // item decode
   logic                  item_neg;
   logic                  item_nonzero;
   logic                  in_range;
   logic                  in_use;
   logic [FIUB-1:0]       idx_plus;
   logic [VALUE_BITS-1:0] item_mag;
   logic                  need_div;

   // divider step and rounding terms
   logic [VALUE_BITS:0]   rem_shift;
   logic                  rem_ge;
   logic [VALUE_BITS:0]   rem_sub;
   logic                  round_up;
   logic [QBITS:0]        quo_sum;
   logic [QBITS:0]        quo_lim;
   logic                  quo_sat;

   always_comb begin
      item_neg     = item_val_ff[VALUE_BITS-1];
      item_nonzero = (item_val_ff != '0);
      in_range     = ({1'b0, item_idx_ff} < DEPTH_LIM);
      in_use       = ({1'b0, item_idx_ff} < fiu_ff);
      idx_plus     = {1'b0, item_idx_ff} + {{(FIUB - 1){1'b0}}, 1'b1};
      item_mag     = item_neg ? (~item_val_ff + {{(VALUE_BITS - 1){1'b0}}, 1'b1})
                              : item_val_ff;
      need_div     = (item_cmd_ff == mafs_pkg::CMD_SCALE) && in_range && in_use
                     && (rd_ff != '0);
      rem_shift    = {rem_ff, num_ff[VALUE_BITS-1]};
      rem_ge       = (rem_shift >= {1'b0, den_ff});
      rem_sub      = rem_shift - {1'b0, den_ff};
      round_up     = ({rem_ff, 1'b0} >= {1'b0, den_ff});
      quo_sum      = {1'b0, quo_ff} + {{QBITS{1'b0}}, round_up};
      quo_lim      = res_neg_ff ? LIM_NEG : LIM_POS;
      quo_sat      = (quo_sum > quo_lim);
   end

   // next values
   always_comb begin
      item_cmd_in   = item_cmd_ff;
      item_idx_in   = item_idx_ff;
      item_val_in   = item_val_ff;
      sweep_in      = sweep_ff;
      step_in       = step_ff;
      fiu_in        = fiu_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      num_in        = num_ff;
      res_in        = res_ff;
      res_neg_in    = res_neg_ff;
      res_stat_in   = res_stat_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = sweep_ff;
      mem_wdata     = '0;

      // request capture
      if (cmd.capture) begin
         item_cmd_in = mafs_pkg::cmd_type'(req_command);
         item_idx_in = req_index;
         item_val_in = req_value;
      end

      // clearing pass, one entry a cycle
      if (cmd.sweep) begin
         mem_we   = 1'b1;
         sweep_in = (sweep_ff == LAST_ADDR) ? '0 : sweep_ff + {{(ADDR_BITS - 1){1'b0}}, 1'b1};
      end

      // command evaluation with the table entry read at capture
      if (cmd.eval) begin
         res_in      = '0;
         res_neg_in  = 1'b0;
         res_stat_in = mafs_pkg::STATUS_OK;
         case (item_cmd_ff)
            mafs_pkg::CMD_OBSERVE: begin
               if (!in_range) begin
                  res_stat_in = mafs_pkg::STATUS_RANGE;
               end else if (item_nonzero) begin
                  if (!item_neg && (item_val_ff > rd_ff)) begin
                     mem_we    = 1'b1;
                     mem_waddr = item_idx_ff[ADDR_BITS-1:0];
                     mem_wdata = item_val_ff;
                  end
                  if (idx_plus > fiu_ff) begin
                     fiu_in = idx_plus;
                  end
               end
            end
            mafs_pkg::CMD_SCALE: begin
               if (!in_range || !in_use) begin
                  res_in      = item_val_ff;
                  res_stat_in = mafs_pkg::STATUS_RANGE;
               end else if (!need_div) begin
                  res_in = item_val_ff;
               end else begin
                  res_neg_in = item_neg;
                  quo_in     = '0;
                  rem_in     = '0;
                  den_in     = rd_ff;
                  num_in     = item_mag;
                  step_in    = '0;
               end
            end
            mafs_pkg::CMD_CLEAR: begin
               fiu_in = '0;
            end
            default: begin
               res_in = '0;
            end
         endcase
      end

      // restoring division, one quotient bit a cycle
      if (cmd.div_step) begin
         num_in  = {num_ff[VALUE_BITS-2:0], 1'b0};
         rem_in  = rem_ge ? rem_sub[VALUE_BITS-1:0] : rem_shift[VALUE_BITS-1:0];
         quo_in  = {quo_ff[QBITS-2:0], rem_ge};
         step_in = step_ff + {{(STEP_BITS - 1){1'b0}}, 1'b1};
      end

      // round to nearest and clamp
      if (cmd.round) begin
         res_in      = quo_sat ? quo_lim[VALUE_BITS-1:0] : quo_sum[VALUE_BITS-1:0];
         res_stat_in = quo_sat ? mafs_pkg::STATUS_SAT : mafs_pkg::STATUS_OK;
      end

      // output register, sign applied here
      if (cmd.load_rsp) begin
         rsp_value_in  = res_neg_ff ? (~res_ff + {{(VALUE_BITS - 1){1'b0}}, 1'b1}) : res_ff;
         rsp_status_in = res_stat_ff;
      end
   end

   // table write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_ff <= mem[req_index[ADDR_BITS-1:0]];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         step_ff  <= '0;
         fiu_ff   <= '0;
      end else begin
         sweep_ff <= sweep_in;
         step_ff  <= step_in;
         fiu_ff   <= fiu_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_cmd_ff   <= item_cmd_in;
      item_idx_ff   <= item_idx_in;
      item_val_ff   <= item_val_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      num_ff        <= num_in;
      res_ff        <= res_in;
      res_neg_ff    <= res_neg_in;
      res_stat_ff   <= res_stat_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      stat.sweep_last = (sweep_ff == LAST_ADDR);
      stat.div_last   = (step_ff == LAST_STEP);
      stat.need_div   = need_div;
      stat.item_cmd   = item_cmd_ff;
   end

   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

### rtl/max_abs_feature_scaler.sv
// one request at a time; observe and no-op go from eval to done, which loads the response
// scale with a nonzero maximum also passes the one-bit-a-cycle divider and rounding
// clear sweeps all min(NUM_FEATURES, 1024) entries, one table entry zeroed per cycle
// a new request is taken in the cycle after the response loads, even while it still waits
// synchronous active-high reset, then a clearing pass over all min(NUM_FEATURES, 1024) entries
// with req_tready low before the first request is taken
module max_abs_feature_scaler #(
   parameter int NUM_FEATURES = mafs_pkg::DEF_NUM_FEATURES,
   parameter int VALUE_BITS   = mafs_pkg::DEF_VALUE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // feature_index, feature_value, zero fill
   input  logic [((mafs_pkg::INDEX_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // command
   input  logic [mafs_pkg::CMD_BITS-1:0]         req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // scaled_value, zero fill
   output logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   // status
   output logic [mafs_pkg::STATUS_BITS-1:0]      rsp_tuser
);

   localparam int RSP_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
   localparam int IB            = mafs_pkg::INDEX_BITS;

   mafs_pkg::ctrl_cmd_type  cmd;
   mafs_pkg::dp_status_type stat;
   logic [VALUE_BITS-1:0]   rsp_value;
   mafs_pkg::status_type    rsp_status;

   mafs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   mafs_datapath #(
      .NUM_FEATURES (NUM_FEATURES),
      .VALUE_BITS   (VALUE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_command (req_tuser),
      .req_index   (req_tdata[IB-1:0]),
      .req_value   (req_tdata[IB+VALUE_BITS-1:IB]),
      .rsp_value   (rsp_value),
      .rsp_status  (rsp_status)
   );

   // response packing
   assign rsp_tdata = RSP_DATA_BITS'(rsp_value);
   assign rsp_tuser = rsp_status;

endmodule

### rtl/mafs_checker.sv
`include "max_abs_feature_scaler_defines.svh"

module mafs_checker #(
   parameter int VALUE_BITS = mafs_pkg::DEF_VALUE_BITS
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   input logic [mafs_pkg::STATUS_BITS-1:0]      rsp_tuser
);

   // clearing pass follows reset, nothing taken or shown
   `MAFS_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !req_tready && !rsp_tvalid, "busy after reset")

   // only one request in the block at a time
   `MAFS_ASSERT(a_one_in_flight, clock, reset, req_tvalid && req_tready |=> !req_tready, "second request taken")

   // status is one of the defined codes
   `MAFS_ASSERT(a_status_code, clock, reset, rsp_tvalid |-> rsp_tuser == mafs_pkg::STATUS_OK || rsp_tuser == mafs_pkg::STATUS_RANGE || rsp_tuser == mafs_pkg::STATUS_SAT, "bad status code")

   // stalled response holds
   `MAFS_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")

endmodule

bind max_abs_feature_scaler mafs_checker #(
   .VALUE_BITS (VALUE_BITS)
) u_mafs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### tb/tb_max_abs_feature_scaler.sv
module tb_max_abs_feature_scaler;
   timeunit 1ns;
   timeprecision 1ps;

   import mafs_pkg::*;

   localparam int FEATURES  = DEF_NUM_FEATURES;
   localparam int VBITS     = DEF_VALUE_BITS;
   localparam int REQ_BITS  = ((INDEX_BITS + VBITS + 7) / 8) * 8;
   localparam int RSP_BITS  = ((VBITS + 7) / 8) * 8;
   localparam int NUM_ROWS  = 25;
   localparam int NUM_RAND  = 850;
   localparam int STALL_MAX = 6000;

   typedef struct packed {
      logic [VBITS-1:0] value;
      status_type       status;
   } scaled_resp_type;

   typedef struct {
      cmd_type          cmd;
      logic [9:0]       idx;
      logic [VBITS-1:0] val;
      bit               typed;
      scaled_resp_type  resp;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_BITS-1:0]   req_tdata = '0;   // feature_index, feature_value, zero fill
   logic [CMD_BITS-1:0]   req_tuser = '0;   // command
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]   rsp_tdata;        // scaled_value
   logic [STATUS_BITS-1:0] rsp_tuser;       // status

   // predictor state: per-feature maxima and the count of features in use
   logic [VBITS-1:0]      max_table [FEATURES] = '{default: '0};
   logic [FIU_BITS-1:0]   features_seen = '0;

   scaled_resp_type       pending_scaled [$];
   int                    mismatch_count = 0;
   int unsigned           send_idle_pct = 28;
   int unsigned           recv_idle_pct = 80;
   int unsigned           stall_cycles = 0;

   // directed requests; typed responses where they are obvious
   stim_row_type directed_rows [NUM_ROWS] = '{
      // empty table after reset: every scale is out of range
      '{CMD_SCALE,   10'd0,    32'h1234_5678, 1'b1, '{32'h1234_5678, STATUS_RANGE}},
      '{CMD_NOP,     10'd1023, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, STATUS_OK}},
      // zero observe leaves the table alone
      '{CMD_OBSERVE, 10'd0,    32'h0000_0000, 1'b1, '{32'h0000_0000, STATUS_OK}},
      '{CMD_SCALE,   10'd0,    32'h0001_0000, 1'b1, '{32'h0001_0000, STATUS_RANGE}},
      // top index with the largest value
      '{CMD_OBSERVE, 10'd1023, 32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, STATUS_OK}},
      '{CMD_SCALE,   10'd1023, 32'h7FFF_FFFF, 1'b1, '{32'h0001_0000, STATUS_OK}},
      '{CMD_SCALE,   10'd1023, 32'h8000_0000, 1'b0, '{32'h0000_0000, STATUS_OK}},
      // zero maximum passes the value through
      '{CMD_SCALE,   10'd5,    32'hDEAD_BEEF, 1'b1, '{32'hDEAD_BEEF, STATUS_OK}},
      // negative observe never raises an entry
      '{CMD_OBSERVE, 10'd5,    32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, STATUS_OK}},
      '{CMD_SCALE,   10'd5,    32'h0000_1234, 1'b1, '{32'h0000_1234, STATUS_OK}},
      // maximum of one half: large values saturate both ways
      '{CMD_OBSERVE, 10'd5,    32'h0000_8000, 1'b1, '{32'h0000_0000, STATUS_OK}},
      '{CMD_SCALE,   10'd5,    32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, STATUS_SAT}},
      '{CMD_SCALE,   10'd5,    32'h8000_0000, 1'b1, '{32'h8000_0000, STATUS_SAT}},
      '{CMD_SCALE,   10'd5,    32'h8000_0001, 1'b0, '{32'h0000_0000, STATUS_OK}},
      // smaller observe keeps the entry
      '{CMD_OBSERVE, 10'd5,    32'h0000_4000, 1'b1, '{32'h0000_0000, STATUS_OK}},
      '{CMD_SCALE,   10'd5,    32'hFFFF_FFFF, 1'b0, '{32'h0000_0000, STATUS_OK}},
      // inexact quotient rounds to nearest
      '{CMD_OBSERVE, 10'd7,    32'h0003_0000, 1'b1, '{32'h0000_0000, STATUS_OK}},
      '{CMD_SCALE,   10'd7,    32'h0001_0000, 1'b0, '{32'h0000_0000, STATUS_OK}},
      // exact half rounds away from zero
      '{CMD_OBSERVE, 10'd9,    32'h0002_0000, 1'b1, '{32'h0000_0000, STATUS_OK}},
      '{CMD_SCALE,   10'd9,    32'h0000_0001, 1'b0, '{32'h0000_0000, STATUS_OK}},
      '{CMD_SCALE,   10'd9,    32'hFFFF_FFFF, 1'b0, '{32'h0000_0000, STATUS_OK}},
      // smallest maximum drives a negative result to the floor
      '{CMD_OBSERVE, 10'd0,    32'h0000_0001, 1'b1, '{32'h0000_0000, STATUS_OK}},
      '{CMD_SCALE,   10'd0,    32'hFFFF_0000, 1'b1, '{32'h8000_0000, STATUS_SAT}},
      // clear empties the table
      '{CMD_CLEAR,   10'd0,    32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, STATUS_OK}},
      '{CMD_SCALE,   10'd1023, 32'h0001_0000, 1'b1, '{32'h0001_0000, STATUS_RANGE}}
   };

   max_abs_feature_scaler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // restoring division of mag * 2^16 by den, rounded half away, clamped to lim
   function automatic logic [63:0] divide_rounded(input logic [63:0] mag,
         input logic [63:0] den, input logic [63:0] lim, output logic sat);
      logic [63:0] rem;
      logic [63:0] quo;
      logic        bit_in;
      rem = '0;
      quo = '0;
      sat = 1'b0;
      for (int b = VBITS + FRAC_BITS - 1; b >= 0; b--) begin
         bit_in = (b >= FRAC_BITS) ? mag[b - FRAC_BITS] : 1'b0;
         rem = {rem[62:0], bit_in};
         if (!sat)
            quo = quo << 1;
         if (rem >= den) begin
            rem = rem - den;
            if (!sat)
               quo[0] = 1'b1;
         end
         if (quo > lim)
            sat = 1'b1;
      end
      if (!sat && rem >= den - rem) begin
         quo = quo + 64'd1;
         if (quo > lim)
            sat = 1'b1;
      end
      return sat ? lim : quo;
   endfunction

   // expected response of one request; updates the predicted table
   function automatic scaled_resp_type scale_feature(input cmd_type cmd, input logic [9:0] idx,
         input logic [VBITS-1:0] val);
      scaled_resp_type  resp;
      logic             neg;
      logic             sat;
      logic [63:0]      mag;
      logic [63:0]      lim;
      logic [63:0]      quo;
      logic [VBITS-1:0] den;
      resp = '{'0, STATUS_OK};
      neg = val[VBITS-1];
      mag = neg ? 64'(-val) : 64'(val);
      case (cmd)
         CMD_OBSERVE: begin
            if (val != '0) begin
               if (!neg && val > max_table[idx])
                  max_table[idx] = val;
               if ({1'b0, idx} + 1'b1 > features_seen)
                  features_seen = {1'b0, idx} + 1'b1;
            end
         end
         CMD_SCALE: begin
            if ({1'b0, idx} >= features_seen) begin
               resp = '{val, STATUS_RANGE};
            end else begin
               den = max_table[idx];
               if (den == '0) begin
                  resp.value = val;
               end else begin
                  lim = neg ? (64'd1 << (VBITS - 1)) : (64'd1 << (VBITS - 1)) - 1;
                  quo = divide_rounded(mag, 64'(den), lim, sat);
                  resp.value = neg ? -quo[VBITS-1:0] : quo[VBITS-1:0];
                  if (sat)
                     resp.status = STATUS_SAT;
               end
            end
         end
         CMD_CLEAR: begin
            foreach (max_table[i])
               max_table[i] = '0;
            features_seen = '0;
         end
         default: ;
      endcase
      return resp;
   endfunction

   // mostly observe and scale, rare clears and no-ops
   function automatic cmd_type random_cmd();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 46)
         return CMD_OBSERVE;
      else if (pick < 94)
         return CMD_SCALE;
      else if (pick < 95)
         return CMD_CLEAR;
      return CMD_NOP;
   endfunction

   // a small working set of features so scales hit trained entries
   function automatic logic [9:0] random_index();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 7)
         return 10'($urandom_range(0, 15));
      else if (pick < 8)
         return 10'($urandom_range(1008, 1023));
      return 10'($urandom);
   endfunction

   // mix of full range, small magnitudes, extremes and scattered magnitudes
   function automatic logic [VBITS-1:0] random_value();
      logic [VBITS-1:0] v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: begin
            v = $urandom_range(0, 1 << 20);
            if ($urandom_range(0, 1))
               v = -v;
         end
         2: begin
            case ($urandom_range(0, 4))
               0: v = '0;
               1: v = 1;
               2: v = '1;
               3: v = 32'h7FFF_FFFF;
               default: v = 32'h8000_0000;
            endcase
         end
         default: begin
            v = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1))
               v = -v;
         end
      endcase
      return v;
   endfunction

   // drive one request, wait for its handshake, record the expected response
   task automatic send_request(input cmd_type cmd, input logic [9:0] idx,
         input logic [VBITS-1:0] val, input bit typed, input scaled_resp_type typed_resp);
      scaled_resp_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_BITS'({val, idx});
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predicted = scale_feature(cmd, idx, val);
      pending_scaled.push_back(typed ? typed_resp : predicted);
   endtask

   // response side backpressure
   always @(posedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

   // compare each response with the oldest pending one
   always @(posedge clock) begin
      scaled_resp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_scaled.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response, expected none, actual value %h status %0d",
                     $time, rsp_tdata[VBITS-1:0], rsp_tuser);
         end else begin
            want = pending_scaled.pop_front();
            if (rsp_tdata[VBITS-1:0] !== want.value) begin
               mismatch_count++;
               $display("%0t: scaled_value mismatch, expected %h actual %h",
                        $time, want.value, rsp_tdata[VBITS-1:0]);
            end
            if (rsp_tuser !== want.status) begin
               mismatch_count++;
               $display("%0t: status mismatch, expected %0d actual %0d",
                        $time, want.status, rsp_tuser);
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_MAX);
         $display("max_abs_feature_scaler test failed");
         $finish;
      end
   end

   // stimulus: directed table, then random requests in three backpressure phases
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i])
         send_request(directed_rows[i].cmd, directed_rows[i].idx, directed_rows[i].val,
                      directed_rows[i].typed, directed_rows[i].resp);
      for (int i = 0; i < NUM_RAND; i++) begin
         if (i == NUM_RAND / 3) begin
            send_idle_pct = 80;
            recv_idle_pct = 28;
         end else if (i == 2 * NUM_RAND / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_request(random_cmd(), random_index(), random_value(), 1'b0, '{'0, STATUS_OK});
      end
      req_tvalid <= 1'b0;
      while (pending_scaled.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatch_count == 0)
         $display("max_abs_feature_scaler test passed");
      else
         $display("max_abs_feature_scaler test failed");
      $finish;
   end

endmodule
